### src/iol_pkg.sv
// Shared types, sizes and codes for the indexed ordered list.
package iol_pkg;

  localparam int Capacity  = 64;
  localparam int DataWidth = 32;
  localparam int IdxW      = $clog2(Capacity);
  localparam int CountW    = $clog2(Capacity + 1);
  localparam int OpW       = 3;
  localparam int PosW      = 7;
  localparam int ItemW     = 32;
  localparam int StatusW   = 2;
  localparam int CmpW      = PosW + CountW;

  typedef logic [DataWidth-1:0] word_t;
  typedef logic [IdxW-1:0]      idx_t;
  typedef logic [CountW-1:0]    count_t;

  typedef enum logic [OpW-1:0] {
    OP_APPEND = 3'd0,
    OP_INSERT = 3'd1,
    OP_REMOVE = 3'd2,
    OP_GET    = 3'd3,
    OP_CLEAR  = 3'd4
  } opcode_e;

  typedef enum logic [StatusW-1:0] {
    ST_DONE   = 2'd0,
    ST_BOUNDS = 2'd1,
    ST_FULL   = 2'd2
  } status_e;

  typedef struct packed {
    logic  ins;
    logic  rem;
    logic  get;
    idx_t  pos;
    word_t word;
  } cell_ctrl_t;

endpackage

### src/iol_if.sv
// Request and response channel interfaces of the indexed ordered list.
interface iol_req_if
  import iol_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [OpW-1:0]   opcode;
  logic [PosW-1:0]  position;
  logic [ItemW-1:0] item_value;

  modport source (output valid, opcode, position, item_value, input ready);
  modport sink (input valid, opcode, position, item_value, output ready);
endinterface

interface iol_rsp_if
  import iol_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [ItemW-1:0]   read_value;
  logic [StatusW-1:0] status;
  logic [CountW-1:0]  entry_count;

  modport source (output valid, read_value, status, entry_count, input ready);
  modport sink (input valid, read_value, status, entry_count, output ready);
endinterface

### src/indexed_ordered_list.sv
// Top level of the indexed ordered list: request decode, cell chain and response register.
// Each request transaction yields exactly one response transaction, one request per clock
// cycle unless the response register stalls: every insert or remove moves all entries of
// the cell chain by one place at once, and a get picks its entry combinationally. The response
// is held in an output register, so a new request is taken whenever that register is empty
// or is being read. Clear only zeroes the count; entries at or past it are never returned.
module indexed_ordered_list
  import iol_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  iol_req_if.sink   req_i,
  iol_rsp_if.source rsp_o
);

  logic        accept;
  logic        out_valid_q;
  count_t      cnt_q;
  count_t      cnt_d;
  logic        full;
  logic        ins_ok;
  logic        rem_ok;
  logic        get_ok;
  status_e     status_d;
  cell_ctrl_t  ctrl;
  word_t       read_d;
  word_t       cell_data [Capacity];
  word_t       cell_rd [Capacity];
  logic [ItemW-1:0]   read_q;
  logic [StatusW-1:0] status_q;
  count_t             rsp_cnt_q;
  logic [CmpW-1:0]    pos_c;
  logic [CmpW-1:0]    cnt_c;

  assign req_i.ready = !out_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;
  assign full        = cnt_q >= count_t'(Capacity);
  assign pos_c       = CmpW'(req_i.position);
  assign cnt_c       = CmpW'(cnt_q);

  always_comb begin
    ins_ok   = 1'b0;
    rem_ok   = 1'b0;
    get_ok   = 1'b0;
    status_d = ST_DONE;
    cnt_d    = cnt_q;
    ctrl.pos = req_i.position[IdxW-1:0];
    unique case (opcode_e'(req_i.opcode))
      OP_APPEND: begin
        ctrl.pos = cnt_q[IdxW-1:0];
        if (full) begin
          status_d = ST_FULL;
        end else begin
          ins_ok = 1'b1;
          cnt_d  = cnt_q + count_t'(1);
        end
      end
      OP_INSERT: begin
        if (pos_c > cnt_c) begin
          status_d = ST_BOUNDS;
        end else if (full) begin
          status_d = ST_FULL;
        end else begin
          ins_ok = 1'b1;
          cnt_d  = cnt_q + count_t'(1);
        end
      end
      OP_REMOVE: begin
        if (pos_c >= cnt_c) begin
          status_d = ST_BOUNDS;
        end else begin
          rem_ok = 1'b1;
          cnt_d  = cnt_q - count_t'(1);
        end
      end
      OP_GET: begin
        if (pos_c >= cnt_c) begin
          status_d = ST_BOUNDS;
        end else begin
          get_ok = 1'b1;
        end
      end
      OP_CLEAR: begin
        cnt_d = '0;
      end
      default: begin
      end
    endcase
    ctrl.ins  = accept && ins_ok;
    ctrl.rem  = accept && rem_ok;
    ctrl.get  = get_ok;
    ctrl.word = req_i.item_value[DataWidth-1:0];
  end

  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    iol_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (idx_t'(i)),
      .ctrl_i  (ctrl),
      .left_i  ((i == 0) ? word_t'(0) : cell_data[(i == 0) ? 0 : i - 1]),
      .right_i ((i == Capacity - 1) ? word_t'(0)
                                    : cell_data[(i == Capacity - 1) ? i : i + 1]),
      .data_o  (cell_data[i]),
      .rd_o    (cell_rd[i])
    );
  end

  always_comb begin
    read_d = '0;
    for (int i = 0; i < Capacity; i++) begin
      read_d = read_d | cell_rd[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        cnt_q       <= cnt_d;
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      read_q    <= ItemW'(read_d);
      status_q  <= status_d;
      rsp_cnt_q <= cnt_d;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.read_value  = read_q;
  assign rsp_o.status      = status_q;
  assign rsp_o.entry_count = rsp_cnt_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= count_t'(Capacity))
    else $error("Entry count exceeds capacity.");

  a_accept_rsp : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q && rsp_cnt_q == cnt_q)
    else $error("Response missing or count mismatch after a transaction.");

  a_full_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q == ST_FULL |-> rsp_cnt_q == count_t'(Capacity))
    else $error("Full status reported on a list that is not full.");

  a_refused_keep : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && status_d != ST_DONE |=> cnt_q == $past(cnt_q))
    else $error("Refused transaction changed the count.");

endmodule

### src/iol_cell.sv
// One list cell: holds one entry and shifts it to or from its neighbours.
module iol_cell
  import iol_pkg::*;
(
  input  logic       clk_i,
  input  idx_t       idx_i,
  input  cell_ctrl_t ctrl_i,
  input  word_t      left_i,
  input  word_t      right_i,
  output word_t      data_o,
  output word_t      rd_o
);

  word_t data_q;
  word_t data_d;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.ins) begin
      if (idx_i == ctrl_i.pos) begin
        data_d = ctrl_i.word;
      end else if (idx_i > ctrl_i.pos) begin
        data_d = left_i;
      end
    end else if (ctrl_i.rem && idx_i >= ctrl_i.pos) begin
      data_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign rd_o   = (ctrl_i.get && idx_i == ctrl_i.pos) ? data_q : '0;

endmodule
